/* design/swm_pkg.sv */
// Shared constants and types for the sliding window maximum block.
package swm_pkg;

	localparam int WINDOW_MAX   = 64;
	localparam int SAMPLE_WIDTH = 16;
	localparam int CNT_W        = $clog2(WINDOW_MAX + 1);

	typedef struct packed {
		logic                    valid;
		logic [SAMPLE_WIDTH-1:0] value;
		logic [CNT_W-1:0]        age;
	} entry_t;

	typedef struct packed {
		logic                    step;
		logic                    shift;
		logic                    purge;
		logic                    last;
		logic [SAMPLE_WIDTH-1:0] sample;
		logic [CNT_W-1:0]        k;
	} ctl_t;

	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0] window_max;
		logic                    out_last;
	} res_t;

endpackage

/* design/swm_in_if.sv */
// Sample request channel: valid, ready and one signed sample with its sequence marker.
interface swm_in_if;
	import swm_pkg::*;

	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           seq_last;

	modport source (output valid, output sample, output seq_last, input ready);
	modport sink (input valid, input sample, input seq_last, output ready);
endinterface

/* design/swm_out_if.sv */
// Result request channel: valid, ready and one window maximum with its sequence marker.
interface swm_out_if;
	import swm_pkg::*;

	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] window_max;
	logic                           out_last;

	modport source (output valid, output window_max, output out_last, input ready);
	modport sink (input valid, input window_max, input out_last, output ready);
endinterface

/* design/swm_cell.sv */
// One deque cell: holds a candidate, filters it against the new sample and takes its neighbor's.
module swm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  swm_pkg::ctl_t  ctl,
	input  logic           head,
	input  logic           prev_keep,
	input  swm_pkg::entry_t nb_ent,
	input  logic           nb_keep,
	output swm_pkg::entry_t ent,
	output logic           keep,
	output swm_pkg::entry_t upd
);
	import swm_pkg::*;

	logic                    valid_q;
	logic [SAMPLE_WIDTH-1:0] value_q;
	logic [CNT_W-1:0]        age_q;
	entry_t src;
	logic   src_keep;
	logic   src_prev;

	assign ent  = '{valid: valid_q, value: value_q, age: age_q};
	assign keep = valid_q && ($signed(value_q) > $signed(ctl.sample))
		&& (age_q < ctl.k);

	always_comb begin
		src      = ctl.shift ? nb_ent : ent;
		src_keep = ctl.shift ? nb_keep : keep;
		src_prev = ctl.shift ? (keep || head) : prev_keep;
		if (src_keep) begin
			upd = '{valid: 1'b1, value: src.value, age: src.age + CNT_W'(1)};
		end else if (src_prev) begin
			upd = '{valid: 1'b1, value: ctl.sample, age: CNT_W'(1)};
		end else begin
			upd = '{valid: 1'b0, value: src.value, age: src.age};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.purge) begin
			valid_q <= nb_ent.valid;
		end else if (ctl.step) begin
			valid_q <= upd.valid && !ctl.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.purge) begin
			value_q <= nb_ent.value;
			age_q   <= nb_ent.age;
		end else if (ctl.step) begin
			value_q <= upd.value;
			age_q   <= upd.age;
		end
	end

endmodule

/* design/swm_obuf.sv */
// Result buffer: output register plus one skid entry.
module swm_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swm_pkg::res_t din,
	output logic          full,
	swm_out_if.source     out_ch
);
	import swm_pkg::*;

	res_t main_q;
	res_t skid_q;
	logic main_v_q;
	logic skid_v_q;
	logic main_free;

	assign main_free         = !main_v_q || out_ch.ready;
	assign full              = skid_v_q;
	assign out_ch.valid      = main_v_q;
	assign out_ch.window_max = main_q.window_max;
	assign out_ch.out_last   = main_q.out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= skid_v_q && push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_v_q ? skid_q : din;
			if (push) begin
				skid_q <= din;
			end
		end else if (push) begin
			skid_q <= din;
		end
	end

`ifndef ASSERT_OFF
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry held while output register empty");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed into a full buffer");
	a_push_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		push && main_v_q && !out_ch.ready |=> skid_v_q)
		else $error("result lost while output stalled");
`endif

endmodule

/* design/sliding_window_maximum_top.sv */
// Sliding window maximum top level: deque cell row, window control and result buffer.
//
// Samples arrive on in_ch (valid/ready, sample, seq_last); results leave on out_ch
// (valid/ready, window_max, out_last). cfg_we/cfg_wdata write window_size; write it
// only while the block is idle. A value of 0 acts as 1, above 64 acts as 64.
// Once window_size samples of a sequence have arrived, every sample gives one result,
// the maximum of the last window_size samples; seq_last clears the window after that
// sample is handled, and its result carries out_last.
// The candidates sit in a row of 64 cells ordered oldest to newest; every accepted
// sample filters all cells at once and each cell takes its own or its neighbor's entry.
// Throughput: one sample per cycle while in_ch.ready is high. After window_size is
// lowered, the expired head entries leave one per cycle before the next sample is taken.
// The result is registered into the output register of the result buffer, or into its
// skid entry while out_ch stalls. A stalled receiver is absorbed by this two-entry buffer;
// in_ch.ready falls when both entries are full or while expired head entries leave.
// Reset clears the window, the sample count and the buffer, and sets window_size to 1.
module sliding_window_maximum_top (
	input  logic                       clk,
	input  logic                       arst_n,
	swm_in_if.sink                     in_ch,
	swm_out_if.source                  out_ch,
	input  logic                       cfg_we,
	input  logic [swm_pkg::CNT_W-1:0]  cfg_wdata
);
	import swm_pkg::*;

	logic [CNT_W-1:0] window_size_q;
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] seen_nxt;
	logic [CNT_W-1:0] k;
	ctl_t             ctl;
	logic             accept;
	logic             buf_full;
	logic             produce;
	res_t             res;

	entry_t ent  [WINDOW_MAX];
	entry_t upd  [WINDOW_MAX];
	logic   keep [WINDOW_MAX];

	always_comb begin
		if (window_size_q == '0) begin
			k = CNT_W'(1);
		end else if (window_size_q > CNT_W'(WINDOW_MAX)) begin
			k = CNT_W'(WINDOW_MAX);
		end else begin
			k = window_size_q;
		end
	end

	assign ctl.purge  = (WINDOW_MAX > 1) && ent[WINDOW_MAX > 1 ? 1 : 0].valid
		&& (ent[WINDOW_MAX > 1 ? 1 : 0].age >= k);
	assign in_ch.ready = !ctl.purge && !buf_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign ctl.step    = accept;
	assign ctl.shift   = accept && ent[0].valid && (ent[0].age >= k);
	assign ctl.last    = in_ch.seq_last;
	assign ctl.sample  = in_ch.sample;
	assign ctl.k       = k;

	assign seen_nxt = (seen_q == CNT_W'(WINDOW_MAX)) ? seen_q : seen_q + CNT_W'(1);
	assign produce  = accept && (seen_nxt >= k);
	assign res      = '{window_max: upd[0].value, out_last: in_ch.seq_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CNT_W'(1);
			seen_q        <= '0;
		end else begin
			if (cfg_we) begin
				window_size_q <= cfg_wdata;
			end
			if (accept) begin
				seen_q <= in_ch.seq_last ? '0 : seen_nxt;
			end
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		entry_t nb_ent;
		logic   nb_keep;
		logic   prev_keep;

		if (i == WINDOW_MAX - 1) begin : g_end
			assign nb_ent  = '{valid: 1'b0, value: '0, age: '0};
			assign nb_keep = 1'b0;
		end else begin : g_mid
			assign nb_ent  = ent[i+1];
			assign nb_keep = keep[i+1];
		end

		if (i == 0) begin : g_head
			assign prev_keep = 1'b1;
		end else begin : g_body
			assign prev_keep = keep[i-1];
		end

		swm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.head      (i == 0),
			.prev_keep (prev_keep),
			.nb_ent    (nb_ent),
			.nb_keep   (nb_keep),
			.ent       (ent[i]),
			.keep      (keep[i]),
			.upd       (upd[i])
		);
	end

	swm_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (produce),
		.din    (res),
		.full   (buf_full),
		.out_ch (out_ch)
	);

`ifndef ASSERT_OFF
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		ent[1].valid |-> ent[0].valid)
		else $error("deque has a hole at the head");
	a_value_order: assert property (@(posedge clk) disable iff (!arst_n)
		ent[1].valid |-> ($signed(ent[0].value) > $signed(ent[1].value)))
		else $error("deque values not decreasing");
	a_age_order: assert property (@(posedge clk) disable iff (!arst_n)
		ent[1].valid |-> (ent[0].age > ent[1].age))
		else $error("deque ages not decreasing");
	a_head_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_ch.seq_last |=> ent[0].valid)
		else $error("head empty after a sample");
`endif

endmodule

/* dv/tb_top.sv */
// Testbench for the sliding window maximum block: directed table, random sequences, deque predictor.
module tb_top;
	import swm_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int NUM_ROWS     = 27;
	localparam int NUM_PHASES   = 12;
	localparam int WIN_PLAN [NUM_PHASES] = '{2, 5, 1, 64, 3, 127, 0, 12, 4, 40, 7, 90};

	typedef enum logic {ROW_WIN, ROW_SAMPLE} row_kind_e;
	typedef enum int {SEQ_NOISE, SEQ_DESCEND, SEQ_ASCEND, SEQ_NARROW} seq_style_e;

	typedef struct packed {
		row_kind_e          kind;
		logic signed [31:0] value;
		logic               last;
		logic               fixed;
		logic signed [31:0] res;
	} row_t;

	typedef struct packed {
		logic fixed;
		res_t res;
	} pin_t;

	localparam row_t DIRECTED [NUM_ROWS] = '{
		'{ROW_SAMPLE,  32767, 1'b0, 1'b1,  32767},
		'{ROW_SAMPLE, -32768, 1'b0, 1'b1, -32768},
		'{ROW_SAMPLE,      0, 1'b1, 1'b1,      0},
		'{ROW_WIN,         0, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,     -1, 1'b1, 1'b1,     -1},
		'{ROW_WIN,         3, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,    100, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,     -5, 1'b1, 1'b0,      0},
		'{ROW_SAMPLE,      5, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,      3, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,      4, 1'b0, 1'b1,      5},
		'{ROW_SAMPLE, -32768, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,  32767, 1'b0, 1'b1,  32767},
		'{ROW_SAMPLE,  32767, 1'b0, 1'b1,  32767},
		'{ROW_SAMPLE,      1, 1'b1, 1'b1,  32767},
		'{ROW_WIN,       127, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,     30, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,     20, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,     10, 1'b0, 1'b0,      0},
		'{ROW_WIN,         2, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,      7, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,     -7, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,      8, 1'b1, 1'b0,      0},
		'{ROW_WIN,        64, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE, -32768, 1'b0, 1'b0,      0},
		'{ROW_SAMPLE,  32767, 1'b1, 1'b0,      0},
		'{ROW_WIN,         1, 1'b0, 1'b0,      0}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                           src_valid  = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] src_sample = '0;
	logic                           src_last   = 1'b0;
	logic                           sink_ready = 1'b0;
	logic                           cfg_we     = 1'b0;
	logic [CNT_W-1:0]               cfg_wdata  = '0;

	logic quiet = 1'b0;

	swm_in_if  in_ch ();
	swm_out_if out_ch ();

	assign in_ch.valid    = src_valid;
	assign in_ch.sample   = src_sample;
	assign in_ch.seq_last = src_last;
	assign out_ch.ready   = sink_ready;

	sliding_window_maximum_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [CNT_W-1:0]               win_len = CNT_W'(1);
	logic signed [SAMPLE_WIDTH-1:0] cand_val [$];
	int                             cand_pos [$];
	int                             seq_pos  = 0;
	int                             seq_seen = 0;

	res_t expected_max_q [$];
	pin_t pinned_q [$];
	int   err_count   = 0;
	int   cycle_count = 0;
	int   prev_sample = 0;

	function automatic int eff_window(input int v);
		if (v == 0)
			return 1;
		if (v > WINDOW_MAX)
			return WINDOW_MAX;
		return v;
	endfunction

	function automatic bit advance_window(input logic signed [SAMPLE_WIDTH-1:0] s,
			input logic l, output res_t r);
		int k;
		bit hit;
		k   = eff_window(int'(win_len));
		hit = 1'b0;
		r   = '0;
		while (cand_val.size() != 0 && s >= cand_val[$]) begin
			cand_val.delete(cand_val.size() - 1);
			cand_pos.delete(cand_pos.size() - 1);
		end
		while (cand_val.size() != 0 && seq_pos - cand_pos[0] >= k) begin
			cand_val.delete(0);
			cand_pos.delete(0);
		end
		cand_val.insert(cand_val.size(), s);
		cand_pos.insert(cand_pos.size(), seq_pos);
		seq_pos++;
		if (seq_seen < WINDOW_MAX)
			seq_seen++;
		if (seq_seen >= k) begin
			r.window_max = cand_val[0];
			r.out_last   = l;
			hit          = 1'b1;
		end
		if (l) begin
			cand_val.delete();
			cand_pos.delete();
			seq_pos  = 0;
			seq_seen = 0;
		end
		return hit;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk)
		sink_ready <= quiet || ($urandom_range(0, 99) >= 7);

	always @(posedge clk) begin
		res_t r;
		pin_t pin;
		bit   hit;
		if (arst_n) begin
			if (cfg_we)
				win_len = cfg_wdata;
			if (in_ch.valid && in_ch.ready) begin
				hit = advance_window(in_ch.sample, in_ch.seq_last, r);
				if (pinned_q.size() != 0) begin
					pin = pinned_q[0];
					pinned_q.delete(0);
					if (pin.fixed) begin
						hit = 1'b1;
						r   = pin.res;
					end
				end
				if (hit)
					expected_max_q.insert(expected_max_q.size(), r);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_max_q.size() == 0) begin
					flag_mismatch($sformatf("window_max %0d out_last %0b with nothing pending",
						out_ch.window_max, out_ch.out_last));
				end else begin
					r = expected_max_q[0];
					expected_max_q.delete(0);
					if (out_ch.window_max !== r.window_max)
						flag_mismatch($sformatf("window_max %0d, want %0d",
							out_ch.window_max, $signed(r.window_max)));
					if (out_ch.out_last !== r.out_last)
						flag_mismatch($sformatf("out_last %0b, want %0b",
							out_ch.out_last, r.out_last));
				end
			end
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic l);
		int n;
		if (!quiet && $urandom_range(0, 99) < 7) begin
			n = $urandom_range(1, 4);
			src_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		src_valid  <= 1'b1;
		src_sample <= s;
		src_last   <= l;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (expected_max_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input int v);
		src_valid <= 1'b0;
		wait_drained();
		// let a request with no result finish
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] next_sample(input seq_style_e style);
		int v;
		case (style)
			SEQ_DESCEND: v = prev_sample - int'($urandom_range(0, 40));
			SEQ_ASCEND:  v = prev_sample + int'($urandom_range(0, 40));
			SEQ_NARROW:  v = int'($urandom_range(0, 6)) - 3;
			default: begin
				case ($urandom_range(0, 9))
					0:       v = 32767;
					1:       v = -32768;
					default: v = int'($signed(16'($urandom)));
				endcase
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		prev_sample = v;
		return SAMPLE_WIDTH'(v);
	endfunction

	initial begin
		pin_t       pin;
		seq_style_e style;
		int         sent;
		int         seq_left;
		int         cur_win;
		int         eff;
		int         phase_len;
		int         p;
		logic signed [SAMPLE_WIDTH-1:0] s;

		sent     = 0;
		seq_left = 0;
		style    = SEQ_NOISE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_WIN) begin
				write_window(DIRECTED[i].value);
			end else begin
				pin.fixed          = DIRECTED[i].fixed;
				pin.res.window_max = DIRECTED[i].res[SAMPLE_WIDTH-1:0];
				pin.res.out_last   = DIRECTED[i].last;
				pinned_q.insert(pinned_q.size(), pin);
				send_sample(DIRECTED[i].value[SAMPLE_WIDTH-1:0], DIRECTED[i].last);
			end
		end

		p = 0;
		while (sent < RANDOM_ITEMS) begin
			cur_win = WIN_PLAN[p % NUM_PHASES];
			write_window(cur_win);
			eff       = eff_window(cur_win);
			phase_len = (eff > 16) ? 250 : 140;
			quiet     = (p == 2);
			for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				if (seq_left == 0) begin
					style       = seq_style_e'($urandom_range(0, 3));
					prev_sample = int'($urandom_range(0, 65535)) - 32768;
					if ($urandom_range(0, 99) < 15)
						seq_left = $urandom_range(1, eff);
					else
						seq_left = $urandom_range(eff, 3 * eff + 6);
				end
				s = next_sample(style);
				seq_left--;
				send_sample(s, seq_left == 0);
				sent++;
				if (p == 4 && i == phase_len / 2) begin
					src_valid <= 1'b0;
					wait_drained();
				end
			end
			p++;
		end
		quiet = 1'b0;

		src_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
